@@ hdl/hfd_pkg.sv @@
// Shared constants, the CRC-8 byte step and the status classifier for the height frame decoder.
// No dependencies; used by height_frame_decoder_top.
package hfd_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned HeightW = 24;
   localparam int unsigned ClassW  = 3;
   localparam int unsigned PosW    = 3;
   localparam int unsigned CsrIdxW = 2;

   localparam logic [ByteW-1:0] CrcPoly        = 8'h31;
   localparam logic [ByteW-1:0] CrcInit        = 8'h00;
   localparam logic [ByteW-1:0] HeaderReset    = 8'h55;
   localparam logic [ByteW-1:0] MeasureCmdReset = 8'h07;

   // CSR indexes
   localparam logic [CsrIdxW-1:0] CsrHeaderValue   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMeasureCommand = 2'd1;

   // Frame byte positions (header is taken while hunting)
   localparam logic [PosW-1:0] PosCommand = 3'd1;
   localparam logic [PosW-1:0] PosStatus  = 3'd2;
   localparam logic [PosW-1:0] PosHeight0 = 3'd3;
   localparam logic [PosW-1:0] PosHeight1 = 3'd4;
   localparam logic [PosW-1:0] PosHeight2 = 3'd5;
   localparam logic [PosW-1:0] PosCrc     = 3'd6;
   localparam logic [PosW-1:0] PosTail    = 3'd7;

   // Status classes
   localparam logic [ClassW-1:0] ClassNormal  = 3'd0;
   localparam logic [ClassW-1:0] ClassMaxKnown = 3'd4;
   localparam logic [ClassW-1:0] ClassUnknown = 3'd5;

   // One byte of CRC-8, MSB first, unrolled over eight bit steps
   function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
      logic [ByteW-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < ByteW; k++) begin
         if (c[ByteW-1]) begin
            c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[ByteW-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [ClassW-1:0] status_to_class(input logic [ByteW-1:0] status);
      if (status <= {{(ByteW-ClassW){1'b0}}, ClassMaxKnown}) begin
         return status[ClassW-1:0];
      end
      return ClassUnknown;
   endfunction

endpackage

@@ hdl/height_frame_decoder_top.sv @@
// Height frame decoder: byte-serial frame hunter, CRC-8 check and result register.
// Depends on hfd_pkg.
//
// One received byte is taken per clock cycle, back to back, on the req_ channel.
// The decoder hunts for header_value, then collects command, status, three
// big-endian height bytes, the CRC byte and the tail byte. A CRC-8 (poly 0x31,
// init 0, MSB first) runs over command through the last height byte; the whole
// eight-bit CRC update is done in the cycle the byte is taken. When the tail of
// a frame whose command equals measure_command is taken, one result transaction
// appears on rsp_ in the next cycle. A single output register holds it; req_ready
// stays high while that register is empty or being drained, so input flow stops
// only while a result waits on a stalled rsp_ready. Other frames give nothing.
// The tail byte's value is not checked. csr_ writes take effect on the next byte.
module height_frame_decoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hfd_pkg::ByteW-1:0]        req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hfd_pkg::ClassW-1:0]       rsp_status_class,
   output logic [hfd_pkg::HeightW-1:0]      rsp_height_mm,
   output logic                             rsp_crc_ok,
   input  logic                             csr_we,
   input  logic [hfd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [hfd_pkg::ByteW-1:0]        csr_wdata
);

   logic [hfd_pkg::ByteW-1:0]   header_ff, header_in;
   logic [hfd_pkg::ByteW-1:0]   meas_cmd_ff, meas_cmd_in;
   logic                        hunting_ff, hunting_in;
   logic [hfd_pkg::PosW-1:0]    pos_ff, pos_in;
   logic [hfd_pkg::ByteW-1:0]   crc_ff, crc_in;
   logic [hfd_pkg::ByteW-1:0]   command_ff, command_in;
   logic [hfd_pkg::ByteW-1:0]   status_ff, status_in;
   logic [hfd_pkg::HeightW-1:0] height_ff, height_in;
   logic                        crc_match_ff, crc_match_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hfd_pkg::ClassW-1:0]  rsp_class_ff, rsp_class_in;
   logic [hfd_pkg::HeightW-1:0] rsp_height_ff, rsp_height_in;
   logic                        rsp_crc_ok_ff, rsp_crc_ok_in;

   logic                        accept;
   logic                        emit;
   logic [hfd_pkg::ByteW-1:0]   crc_next;
   logic [hfd_pkg::ClassW-1:0]  cls;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign crc_next  = hfd_pkg::crc8_step(crc_ff, req_rx_byte);
   assign cls       = hfd_pkg::status_to_class(status_ff);

   // Configuration
   always_comb begin
      header_in   = header_ff;
      meas_cmd_in = meas_cmd_ff;
      if (csr_we) begin
         case (csr_index)
            hfd_pkg::CsrHeaderValue:    header_in   = csr_wdata;
            hfd_pkg::CsrMeasureCommand: meas_cmd_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame tracking
   always_comb begin
      hunting_in   = hunting_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      command_in   = command_ff;
      status_in    = status_ff;
      height_in    = height_ff;
      crc_match_in = crc_match_ff;
      emit         = 1'b0;
      if (accept) begin
         if (hunting_ff) begin
            if (req_rx_byte == header_ff) begin
               hunting_in   = 1'b0;
               pos_in       = hfd_pkg::PosCommand;
               crc_in       = hfd_pkg::CrcInit;
               height_in    = '0;
               crc_match_in = 1'b0;
            end
         end else begin
            pos_in = pos_ff + 3'd1;
            case (pos_ff)
               hfd_pkg::PosCommand: begin
                  command_in = req_rx_byte;
                  crc_in     = crc_next;
               end
               hfd_pkg::PosStatus: begin
                  status_in = req_rx_byte;
                  crc_in    = crc_next;
               end
               hfd_pkg::PosHeight0, hfd_pkg::PosHeight1, hfd_pkg::PosHeight2: begin
                  height_in = {height_ff[hfd_pkg::HeightW-hfd_pkg::ByteW-1:0], req_rx_byte};
                  crc_in    = crc_next;
               end
               hfd_pkg::PosCrc: begin
                  crc_match_in = (req_rx_byte == crc_ff);
               end
               default: begin
                  // tail byte closes the frame
                  hunting_in = 1'b1;
                  pos_in     = '0;
                  emit       = (command_ff == meas_cmd_ff);
               end
            endcase
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_class_in  = rsp_class_ff;
      rsp_height_in = rsp_height_ff;
      rsp_crc_ok_in = rsp_crc_ok_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_class_in  = cls;
         rsp_height_in = (cls == hfd_pkg::ClassNormal) ? height_ff : '0;
         rsp_crc_ok_in = crc_match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= hfd_pkg::HeaderReset;
         meas_cmd_ff  <= hfd_pkg::MeasureCmdReset;
         hunting_ff   <= 1'b1;
         pos_ff       <= '0;
         crc_ff       <= hfd_pkg::CrcInit;
         command_ff   <= '0;
         status_ff    <= '0;
         height_ff    <= '0;
         crc_match_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         meas_cmd_ff  <= meas_cmd_in;
         hunting_ff   <= hunting_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         command_ff   <= command_in;
         status_ff    <= status_in;
         height_ff    <= height_in;
         crc_match_ff <= crc_match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff  <= rsp_class_in;
      rsp_height_ff <= rsp_height_in;
      rsp_crc_ok_ff <= rsp_crc_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_class = rsp_class_ff;
   assign rsp_height_mm    = rsp_height_ff;
   assign rsp_crc_ok       = rsp_crc_ok_ff;

   // In a frame the position never sits at the hunting slot
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      !hunting_ff |-> pos_ff != '0)
      else $error("frame position zero outside hunting");

   // A non-header byte while hunting keeps the decoder hunting
   a_hunt_hold: assert property (@(posedge clock) disable iff (reset)
      accept && hunting_ff && req_rx_byte != header_ff |=> hunting_ff)
      else $error("left hunting without header");

   // The tail byte always returns to hunting
   a_tail_hunt: assert property (@(posedge clock) disable iff (reset)
      accept && !hunting_ff && pos_ff == hfd_pkg::PosTail |=> hunting_ff && pos_ff == '0)
      else $error("tail did not restart hunting");

   // A new result only follows an accepted tail transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept) && !$past(hunting_ff)
                              && $past(pos_ff) == hfd_pkg::PosTail)
      else $error("result without frame tail");

   // Height is reported only for the normal class
   a_height_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff != hfd_pkg::ClassNormal |-> rsp_height_ff == '0)
      else $error("height given for non-normal status");

endmodule
